@@ design/cesc_pkg.sv @@
// Shared types and constants for the C escape decoder.
// No dependencies; every other file in design/ imports this package.
`default_nettype none

package cesc_pkg;

	localparam logic [7:0] CH_BACKSLASH    = 8'h5C;
	localparam logic [7:0] OCT_THIRD_LIMIT = 8'h20;
	localparam logic [4:0] OCT_DIGIT_HIGH  = 5'b00110; // '0'..'7' share these upper bits

	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_V = 8'h76;

	typedef enum logic [3:0] {
		MODE_NORMAL = 4'b0001,
		MODE_ESCAPE = 4'b0010,
		MODE_OCT1   = 4'b0100,
		MODE_OCT2   = 4'b1000
	} cesc_mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} cesc_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       string_valid;
		logic       last_out;
	} cesc_out_t;

	// One classified input byte: one or two decoded bytes for the back end.
	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       two;
		logic       valid;
		logic       last;
	} cesc_job_t;

	function automatic logic is_octal(input logic [7:0] b);
		return b[7:3] == OCT_DIGIT_HIGH;
	endfunction

	function automatic logic [7:0] esc_map(input logic [7:0] b);
		logic [7:0] c;
		case (b)
			CH_A:    c = 8'h07;
			CH_B:    c = 8'h08;
			CH_F:    c = 8'h0C;
			CH_N:    c = 8'h0A;
			CH_R:    c = 8'h0D;
			CH_T:    c = 8'h09;
			CH_V:    c = 8'h0B;
			default: c = b;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

@@ design/c_escape_decoder_core.sv @@
// Top level of the streaming C escape decoder: front end, job queue, back end.
// Depends on cesc_pkg, cesc_front, cesc_queue and cesc_back.
//
//   channel  | dir | handshake            | payload
//   raw      | in  | raw_valid/raw_stall  | cesc_in_t  {in_byte, last_byte}
//   dec      | out | dec_valid/dec_stall  | cesc_out_t {out_byte, string_valid, last_out}
//
// A raw byte is accepted every cycle while the job queue has room.
// The first decoded byte is written into a queue slot at the accepting edge and is
// then loaded into the output register when that register is free.
// The output register emits one byte a cycle while dec_stall is low; a byte that ends an
// octal escape and yields two results gives two output bytes, absorbed by the queue.
// Reset clears the escape state, the queue pointers and the output valid.
// dec_stall backs up through the queue to raw_stall once QUEUE_DEPTH jobs wait.
`default_nettype none

module c_escape_decoder_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                raw_valid,
	input  wire cesc_pkg::cesc_in_t  raw,
	output logic                     raw_stall,
	output logic                     dec_valid,
	output cesc_pkg::cesc_out_t      dec,
	input  wire logic                dec_stall
);
	import cesc_pkg::*;

	logic      q_push, q_pop, q_full, q_empty;
	cesc_job_t push_job, head_job;

	cesc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw_valid (raw_valid),
		.raw       (raw),
		.raw_stall (raw_stall),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (push_job)
	);

	cesc_queue #(
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (push_job),
		.pop    (q_pop),
		.rd_job (head_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	cesc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.dec_valid (dec_valid),
		.dec       (dec),
		.dec_stall (dec_stall)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job popped from an empty queue");

	a_last_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(raw_valid && !raw_stall && raw.last_byte) |-> q_push)
		else $error("final byte of a string produced no job");

endmodule

`default_nettype wire

@@ design/cesc_front.sv @@
// Front end: accepts raw bytes, tracks escape state, and pushes decoded jobs.
// Depends on cesc_pkg.
`default_nettype none

module cesc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               raw_valid,
	input  wire cesc_pkg::cesc_in_t raw,
	output logic                    raw_stall,
	input  wire logic               q_full,
	output logic                    q_push,
	output cesc_pkg::cesc_job_t     q_job
);
	import cesc_pkg::*;

	cesc_mode_t mode_q;
	logic [7:0] octal_q;
	logic       null_q;

	cesc_mode_t mode_nxt;
	logic [7:0] octal_nxt;
	logic       e0, e1, oct0;
	logic [7:0] byte0, byte1;
	logic [7:0] b;
	logic       last, accept, dig, bslash, null_nxt;
	logic [7:0] v;

	assign b         = raw.in_byte;
	assign last      = raw.last_byte;
	assign raw_stall = q_full;
	assign accept    = raw_valid && !q_full;
	assign dig       = is_octal(b);
	assign bslash    = (b == CH_BACKSLASH);
	assign v         = {octal_q[4:0], b[2:0]};

	always_comb begin
		mode_nxt  = MODE_NORMAL;
		octal_nxt = octal_q;
		e0        = 1'b0;
		e1        = 1'b0;
		oct0      = 1'b0;
		byte0     = b;
		byte1     = b;
		case (mode_q)
			MODE_NORMAL: begin
				if (bslash && !last) begin
					mode_nxt = MODE_ESCAPE;
				end else begin
					e0 = 1'b1;
				end
			end
			MODE_ESCAPE: begin
				if (dig) begin
					if (last) begin
						e0    = 1'b1;
						oct0  = 1'b1;
						byte0 = {5'd0, b[2:0]};
					end else begin
						octal_nxt = {5'd0, b[2:0]};
						mode_nxt  = MODE_OCT1;
					end
				end else begin
					e0    = 1'b1;
					byte0 = esc_map(b);
				end
			end
			MODE_OCT1, MODE_OCT2: begin
				if (dig) begin
					if (mode_q == MODE_OCT1 && v < OCT_THIRD_LIMIT && !last) begin
						octal_nxt = v;
						mode_nxt  = MODE_OCT2;
					end else begin
						e0    = 1'b1;
						oct0  = 1'b1;
						byte0 = v;
					end
				end else begin
					// emit the pending value, then treat this byte as a normal one
					e0    = 1'b1;
					oct0  = 1'b1;
					byte0 = octal_q;
					if (bslash && !last) begin
						mode_nxt = MODE_ESCAPE;
					end else begin
						e1 = 1'b1;
					end
				end
			end
			default: begin
				mode_nxt = MODE_NORMAL;
			end
		endcase
	end

	assign null_nxt = null_q || (e0 && oct0 && byte0 == 8'd0);

	assign q_push      = accept && e0;
	assign q_job.byte0 = byte0;
	assign q_job.byte1 = byte1;
	assign q_job.two   = e1;
	assign q_job.valid = !null_nxt;
	assign q_job.last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			octal_q <= 8'd0;
			null_q  <= 1'b0;
		end else if (accept) begin
			if (last) begin
				mode_q  <= MODE_NORMAL;
				octal_q <= 8'd0;
				null_q  <= 1'b0;
			end else begin
				mode_q  <= mode_nxt;
				octal_q <= octal_nxt;
				null_q  <= null_nxt;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/cesc_queue.sv @@
// Short job queue between the front and back ends of the decoder.
// Depends on cesc_pkg for the job type. Depth must be at least 2.
`default_nettype none

module cesc_queue #(
	parameter int Depth = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire cesc_pkg::cesc_job_t wr_job,
	input  wire logic                pop,
	output cesc_pkg::cesc_job_t      rd_job,
	output logic                     full,
	output logic                     empty
);
	import cesc_pkg::*;

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	cesc_job_t       slots_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full   = (cnt_q == CntW'(Depth));
	assign empty  = (cnt_q == '0);
	assign rd_job = slots_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/cesc_back.sv @@
// Back end: drains jobs and presents one decoded byte per cycle on the output while dec_stall is low.
// Depends on cesc_pkg.
`default_nettype none

module cesc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cesc_pkg::cesc_job_t job,
	input  wire logic                q_empty,
	output logic                     q_pop,
	output logic                     dec_valid,
	output cesc_pkg::cesc_out_t      dec,
	input  wire logic                dec_stall
);
	import cesc_pkg::*;

	logic      dec_valid_q;
	cesc_out_t dec_q;
	logic      split_q;   // first byte of a two-byte job already sent
	logic      slot_free, load, first_of_two;

	assign slot_free    = !dec_valid_q || !dec_stall;
	assign load         = slot_free && !q_empty;
	assign first_of_two = job.two && !split_q;
	assign q_pop        = load && !first_of_two;
	assign dec_valid    = dec_valid_q;
	assign dec          = dec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_valid_q <= 1'b0;
			split_q     <= 1'b0;
		end else if (slot_free) begin
			dec_valid_q <= !q_empty;
			if (!q_empty) begin
				split_q <= first_of_two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dec_q.out_byte     <= split_q ? job.byte1 : job.byte0;
			dec_q.string_valid <= job.valid;
			// hold off the end mark until the second byte of a split job
			dec_q.last_out     <= job.last && !first_of_two;
		end
	end

endmodule

`default_nettype wire
